>>> src/pst_pkg.sv
package pst_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;
    localparam int IN_TIME_W      = 32;
    localparam int ID_W           = 4;
    localparam int COUNT_W        = 5;
    localparam int RESULT_LIMIT   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_CREATE   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2,
        ST_NONE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // token that walks down the slot chain, one slot per cycle while the chain shifts
    typedef struct packed {
        logic               active;
        logic               taken;
        logic [COUNT_W-1:0] cnt;
    } t_token;

endpackage

>>> src/pst_cell.sv
module pst_cell import pst_pkg::*; #(
    parameter int INDEX     = 0,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  t_cmd                  i_cmd,
    input  logic [(TIME_BITS < IN_TIME_W ? TIME_BITS : IN_TIME_W)-1:0] i_now,
    input  logic [(TIME_BITS < IN_TIME_W ? TIME_BITS : IN_TIME_W)-1:0] i_period,
    input  logic [ID_W-1:0]       i_idx,
    input  t_token                i_tok,
    output t_token                o_tok,
    output logic                  o_hit
);

    localparam int SW = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;

    logic          r_used;
    logic          r_ready;
    logic [SW-1:0] r_period;
    logic [SW-1:0] r_last;
    t_token        r_tok;

    logic          n_used;
    logic          n_ready;
    logic [SW-1:0] n_period;
    logic [SW-1:0] n_last;

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_due;

    // elapsed time at TIME_BITS width; wrap-safe when TIME_BITS <= IN_TIME_W
    assign w_elapsed = TIME_BITS'(i_now) - TIME_BITS'(r_last);
    assign w_due     = r_used && (w_elapsed >= TIME_BITS'(r_period));

    always_comb begin
        n_used   = r_used;
        n_ready  = r_ready;
        n_period = r_period;
        n_last   = r_last;
        o_tok    = r_tok;
        o_hit    = 1'b0;
        if (r_tok.active) begin
            unique case (i_cmd)
                CMD_CREATE: begin
                    if (!r_used && !r_tok.taken) begin
                        n_used      = 1'b1;
                        n_ready     = 1'b0;
                        n_period    = i_period;
                        n_last      = i_now;
                        o_tok.taken = 1'b1;
                        o_hit       = 1'b1;
                    end
                end
                CMD_DELETE: begin
                    if (32'(i_idx) == 32'(INDEX)) begin
                        n_used   = 1'b0;
                        n_ready  = 1'b0;
                        n_period = '0;
                        n_last   = '0;
                    end
                end
                CMD_TICK: begin
                    if (w_due) begin
                        n_last  = i_now;
                        n_ready = 1'b1;
                        if (r_tok.cnt != COUNT_MAX) begin
                            o_tok.cnt = r_tok.cnt + COUNT_W'(1);
                        end
                    end
                end
                CMD_DISPATCH: begin
                    if (r_ready && (r_tok.cnt < COUNT_W'(RESULT_LIMIT))) begin
                        n_ready   = 1'b0;
                        o_tok.cnt = r_tok.cnt + COUNT_W'(1);
                        o_hit     = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_ready <= 1'b0;
            r_tok   <= '0;
        end else if (i_shift) begin
            r_used  <= n_used;
            r_ready <= n_ready;
            r_tok   <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_period <= n_period;
            r_last   <= n_last;
        end
    end

endmodule

>>> src/periodic_task_scheduler.sv
// Periodic task scheduler: SLOT_COUNT task slots, each held in one cell of a chain.
//
// Input channel (i_in_valid / o_in_stall) carries one command item: create,
// delete, tick or dispatch, with now_time, task_period and slot_index.
// Output channel (o_out_valid / i_out_stall) carries result items: slot_id,
// status, ready_count and last_result; last_result marks the final result of
// the command. Every command gives one result, a dispatch gives one per slot
// it reports (at most 16, lowest slots first).
//
// Timing: an accepted item launches a token into cell 0; the token moves one
// cell per cycle while the scan is not held. After the last cell, the finish
// state places the final result in the output register; the block then goes
// back to idle and takes the next item there.
// The block takes one item at a time; o_in_stall is high while an item runs.
//
// A stall on the output holds the output register; the scan also holds when a
// dispatch needs to hand a result over and the register is still full.
// Reset (synchronous, i_rst_n low) frees all slots, clears all ready marks and
// empties the output register.
module periodic_task_scheduler import pst_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_cmd,
    input  logic [IN_TIME_W-1:0] i_now_time,
    input  logic [IN_TIME_W-1:0] i_task_period,
    input  logic [ID_W-1:0]      i_slot_index,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ID_W-1:0]      o_slot_id,
    output logic [1:0]           o_status,
    output logic [COUNT_W-1:0]   o_ready_count,
    output logic                 o_last_result
);

    localparam int SW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
    localparam int POS_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // command registers, broadcast to all cells
    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;
    logic [SW-1:0]      r_now;
    logic [SW-1:0]      r_period;
    logic [ID_W-1:0]    r_idx;
    logic [POS_W-1:0]   r_pos;

    // slot found by create, or last slot found by dispatch, not yet sent
    logic               r_pend_valid;
    logic [ID_W-1:0]    r_pend_id;
    logic [COUNT_W-1:0] r_fin_cnt;

    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_last;

    t_token             w_tok [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] w_hit;
    logic               w_any_hit;
    logic               w_out_free;
    logic               w_launch;
    logic               w_adv;
    logic               w_push;
    logic               w_final;
    logic               w_shift;
    logic               w_at_end;
    logic [ID_W-1:0]    w_pos_id;
    logic [ID_W-1:0]    w_fin_id;
    t_status            w_fin_status;
    logic [COUNT_W-1:0] w_fin_cnt;
    logic               w_bad_idx;

    assign w_any_hit  = |w_hit;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_at_end   = (r_pos == POS_W'(SLOT_COUNT - 1));
    assign w_pos_id   = ID_W'(r_pos);
    assign w_bad_idx  = (32'(r_idx) >= 32'(SLOT_COUNT));
    assign w_shift    = w_launch || w_adv;

    // launch token into the head of the chain
    always_comb begin
        w_tok[0] = '0;
        if (w_launch) begin
            w_tok[0].active = 1'b1;
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        pst_cell #(
            .INDEX    (g),
            .TIME_BITS(TIME_BITS)
        ) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_cmd   (r_cmd),
            .i_now   (r_now),
            .i_period(r_period),
            .i_idx   (r_idx),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_hit   (w_hit[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_adv && w_at_end) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_launch   = 1'b0;
        w_adv      = 1'b0;
        w_push     = 1'b0;
        w_final    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                w_launch   = i_in_valid;
            end
            S_SCAN: begin
                // a second dispatch hit pushes the held slot out first
                w_push = (r_cmd == CMD_DISPATCH) && w_any_hit && r_pend_valid;
                w_adv  = !w_push || w_out_free;
                w_push = w_push && w_out_free;
            end
            S_FINISH: begin
                w_final = w_out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // final result of the command
    always_comb begin
        w_fin_id     = '0;
        w_fin_status = ST_OK;
        w_fin_cnt    = '0;
        unique case (r_cmd)
            CMD_CREATE: begin
                w_fin_id     = r_pend_valid ? r_pend_id : '0;
                w_fin_status = r_pend_valid ? ST_OK : ST_FULL;
            end
            CMD_DELETE: begin
                w_fin_id     = r_idx;
                w_fin_status = w_bad_idx ? ST_BAD : ST_OK;
            end
            CMD_TICK: begin
                w_fin_cnt = r_fin_cnt;
            end
            CMD_DISPATCH: begin
                w_fin_id     = r_pend_valid ? r_pend_id : '0;
                w_fin_status = r_pend_valid ? ST_OK : ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_launch) begin
                r_pend_valid <= 1'b0;
            end else if (w_adv && w_any_hit) begin
                r_pend_valid <= 1'b1;
            end
            if (w_push || w_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_launch) begin
            r_cmd    <= t_cmd'(i_cmd);
            r_now    <= SW'(i_now_time);
            r_period <= SW'(i_task_period);
            r_idx    <= i_slot_index;
            r_pos    <= '0;
        end else if (w_adv) begin
            r_pos <= r_pos + POS_W'(1);
        end
        // hold the newest hit slot
        if (w_adv && w_any_hit) begin
            r_pend_id <= w_pos_id;
        end
        if (w_adv && w_at_end) begin
            r_fin_cnt <= w_tok[SLOT_COUNT].cnt;
        end
        if (w_push) begin
            r_out_id     <= r_pend_id;
            r_out_status <= ST_OK;
            r_out_cnt    <= '0;
            r_out_last   <= 1'b0;
        end else if (w_final) begin
            r_out_id     <= w_fin_id;
            r_out_status <= w_fin_status;
            r_out_cnt    <= w_fin_cnt;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_id     = r_out_id;
    assign o_status      = r_out_status;
    assign o_ready_count = r_out_cnt;
    assign o_last_result = r_out_last;

endmodule
